// ----- rtl/mpd_pkg.sv -----
package mpd_pkg;

  localparam int unsigned SLOT_COUNT = 64;
  localparam int unsigned BITS_W = 15;
  localparam int unsigned CNT_W = 4;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned WEIGHT_W = 9;
  localparam int unsigned SUM_W = WEIGHT_W + 1;
  localparam logic [CHAR_W-1:0] UNKNOWN_CHAR = 7'h3F;

  typedef struct packed {
    logic [6:0]          bits;
    logic [2:0]          len;
    logic [CHAR_W-1:0]   ch;
    logic [WEIGHT_W-1:0] weight;
  } row_t;

  typedef struct packed {
    logic                hit;
    logic [CHAR_W-1:0]   ch;
    logic [WEIGHT_W-1:0] weight;
  } hit_t;

  typedef struct packed {
    logic              ok;
    logic [CHAR_W-1:0] lch;
    logic [CHAR_W-1:0] rch;
    logic [SUM_W-1:0]  sum;
  } split_t;

  typedef struct packed {
    logic              skip;
    logic              room2;
    logic              exact;
    logic [CHAR_W-1:0] exact_ch;
  } ctl_t;

  function automatic row_t code_row(input logic [5:0] idx);
    row_t r;
    r = '0;
    unique case (idx)
      6'd0:  r = '{7'd0,  3'd1, 7'h45, 9'd321};
      6'd1:  r = '{7'd1,  3'd1, 7'h54, 9'd236};
      6'd2:  r = '{7'd0,  3'd2, 7'h49, 9'd115};
      6'd3:  r = '{7'd2,  3'd2, 7'h41, 9'd127};
      6'd4:  r = '{7'd1,  3'd2, 7'h4E, 9'd103};
      6'd5:  r = '{7'd3,  3'd2, 7'h4D, 9'd48};
      6'd6:  r = '{7'd0,  3'd3, 7'h53, 9'd101};
      6'd7:  r = '{7'd4,  3'd3, 7'h55, 9'd48};
      6'd8:  r = '{7'd2,  3'd3, 7'h52, 9'd84};
      6'd9:  r = '{7'd6,  3'd3, 7'h57, 9'd38};
      6'd10: r = '{7'd1,  3'd3, 7'h44, 9'd68};
      6'd11: r = '{7'd5,  3'd3, 7'h4B, 9'd17};
      6'd12: r = '{7'd3,  3'd3, 7'h47, 9'd31};
      6'd13: r = '{7'd7,  3'd3, 7'h4F, 9'd127};
      6'd14: r = '{7'd0,  3'd4, 7'h48, 9'd103};
      6'd15: r = '{7'd8,  3'd4, 7'h56, 9'd16};
      6'd16: r = '{7'd4,  3'd4, 7'h46, 9'd37};
      6'd17: r = '{7'd2,  3'd4, 7'h4C, 9'd66};
      6'd18: r = '{7'd6,  3'd4, 7'h50, 9'd31};
      6'd19: r = '{7'd14, 3'd4, 7'h4A, 9'd3};
      6'd20: r = '{7'd1,  3'd4, 7'h42, 9'd25};
      6'd21: r = '{7'd9,  3'd4, 7'h58, 9'd3};
      6'd22: r = '{7'd5,  3'd4, 7'h43, 9'd44};
      6'd23: r = '{7'd13, 3'd4, 7'h59, 9'd32};
      6'd24: r = '{7'd3,  3'd4, 7'h5A, 9'd2};
      6'd25: r = '{7'd11, 3'd4, 7'h51, 9'd2};
      6'd26: r = '{7'd30, 3'd5, 7'h31, 9'd10};
      6'd27: r = '{7'd28, 3'd5, 7'h32, 9'd10};
      6'd28: r = '{7'd24, 3'd5, 7'h33, 9'd10};
      6'd29: r = '{7'd16, 3'd5, 7'h34, 9'd10};
      6'd30: r = '{7'd0,  3'd5, 7'h35, 9'd10};
      6'd31: r = '{7'd1,  3'd5, 7'h36, 9'd10};
      6'd32: r = '{7'd3,  3'd5, 7'h37, 9'd10};
      6'd33: r = '{7'd7,  3'd5, 7'h38, 9'd10};
      6'd34: r = '{7'd15, 3'd5, 7'h39, 9'd10};
      6'd35: r = '{7'd31, 3'd5, 7'h30, 9'd10};
      6'd36: r = '{7'd42, 3'd6, 7'h2E, 9'd5};
      6'd37: r = '{7'd51, 3'd6, 7'h2C, 9'd5};
      6'd38: r = '{7'd12, 3'd6, 7'h3F, 9'd5};
      6'd39: r = '{7'd30, 3'd6, 7'h27, 9'd3};
      6'd40: r = '{7'd53, 3'd6, 7'h21, 9'd3};
      6'd41: r = '{7'd9,  3'd5, 7'h2F, 9'd5};
      6'd42: r = '{7'd13, 3'd5, 7'h28, 9'd3};
      6'd43: r = '{7'd45, 3'd6, 7'h29, 9'd3};
      6'd44: r = '{7'd2,  3'd5, 7'h26, 9'd3};
      6'd45: r = '{7'd7,  3'd6, 7'h3A, 9'd3};
      6'd46: r = '{7'd21, 3'd6, 7'h3B, 9'd3};
      6'd47: r = '{7'd17, 3'd5, 7'h3D, 9'd5};
      6'd48: r = '{7'd10, 3'd5, 7'h2B, 9'd3};
      6'd49: r = '{7'd33, 3'd6, 7'h2D, 9'd3};
      6'd50: r = '{7'd44, 3'd6, 7'h5F, 9'd3};
      6'd51: r = '{7'd18, 3'd6, 7'h22, 9'd3};
      6'd52: r = '{7'd72, 3'd7, 7'h24, 9'd3};
      6'd53: r = '{7'd22, 3'd6, 7'h40, 9'd3};
      default: r = '0;
    endcase
    return r;
  endfunction

  // The lowest matching slot wins, so the scan runs from the top down.
  function automatic hit_t lookup(input logic [BITS_W-1:0] bits,
                                  input logic [CNT_W-1:0] len,
                                  input int unsigned entries);
    hit_t h;
    row_t r;
    h = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      r = code_row(6'(i));
      if (i < entries && r.len != 3'd0 && {1'b0, r.len} == len &&
          {8'd0, r.bits} == bits) begin
        h.hit = 1'b1;
        h.ch = r.ch;
        h.weight = r.weight;
      end
    end
    return h;
  endfunction

endpackage

// ----- rtl/mpd_match.sv -----
module mpd_match #(
  parameter int MAX_ELEMENTS = 15,
  parameter int TABLE_ENTRIES = 54
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    in_valid,
  input  logic [mpd_pkg::BITS_W-1:0]              element_bits,
  input  logic [mpd_pkg::CNT_W-1:0]               element_count,
  input  logic [1:0]                              room,
  output logic                                    out_valid,
  output mpd_pkg::ctl_t                           ctl,
  output mpd_pkg::split_t [MAX_ELEMENTS-2:0]      splits
);

  localparam int NSPLIT = MAX_ELEMENTS - 1;

  logic                          v1;
  logic [mpd_pkg::BITS_W-1:0]    bits1;
  logic [mpd_pkg::CNT_W-1:0]     cnt1;
  logic                          skip1;
  logic                          room21;
  logic [mpd_pkg::CNT_W-1:0]     cnt_next;
  logic [mpd_pkg::BITS_W-1:0]    bits_next;
  mpd_pkg::hit_t                 exact;
  mpd_pkg::split_t [NSPLIT-1:0]  splits_next;

  always_comb begin
    cnt_next = (element_count > mpd_pkg::CNT_W'(MAX_ELEMENTS)) ?
               mpd_pkg::CNT_W'(MAX_ELEMENTS) : element_count;
    bits_next = element_bits & mpd_pkg::BITS_W'((32'd1 << cnt_next) - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      bits1 <= bits_next;
      cnt1 <= cnt_next;
      skip1 <= (cnt_next == '0) || (room == 2'd0);
      room21 <= room[1];
    end
  end

  assign exact = mpd_pkg::lookup(bits1, cnt1, TABLE_ENTRIES);

  for (genvar k = 0; k < NSPLIT; k++) begin : g_split
    localparam int P = k + 1;
    localparam logic [mpd_pkg::BITS_W-1:0] LMASK = mpd_pkg::BITS_W'((32'd1 << P) - 32'd1);
    mpd_pkg::hit_t lh;
    mpd_pkg::hit_t rh;
    assign lh = mpd_pkg::lookup(bits1 & LMASK, mpd_pkg::CNT_W'(P), TABLE_ENTRIES);
    assign rh = mpd_pkg::lookup(bits1 >> P, cnt1 - mpd_pkg::CNT_W'(P), TABLE_ENTRIES);
    always_comb begin
      splits_next[k].ok = (mpd_pkg::CNT_W'(P) < cnt1) && lh.hit && rh.hit;
      splits_next[k].lch = lh.ch;
      splits_next[k].rch = rh.ch;
      splits_next[k].sum = {1'b0, lh.weight} + {1'b0, rh.weight};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
    if (en) begin
      ctl.skip <= skip1;
      ctl.room2 <= room21;
      ctl.exact <= exact.hit;
      ctl.exact_ch <= exact.ch;
      splits <= splits_next;
    end
  end

endmodule

// ----- rtl/mpd_pick.sv -----
module mpd_pick #(
  parameter int MAX_ELEMENTS = 15
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  mpd_pkg::ctl_t                       ctl,
  input  mpd_pkg::split_t [MAX_ELEMENTS-2:0]  splits,
  output logic                                out_valid,
  output logic [1:0]                          char_count,
  output logic [mpd_pkg::CHAR_W-1:0]          first_char,
  output logic [mpd_pkg::CHAR_W-1:0]          second_char
);

  localparam int NSPLIT = MAX_ELEMENTS - 1;
  localparam int HALF = NSPLIT / 2;

  logic            v3;
  mpd_pkg::ctl_t   ctl3;
  mpd_pkg::split_t lo3;
  mpd_pkg::split_t hi3;
  mpd_pkg::split_t lo_next;
  mpd_pkg::split_t hi_next;
  mpd_pkg::split_t best;

  // Earlier splits win ties, so a later one replaces only on a larger sum.
  always_comb begin
    lo_next = '0;
    for (int k = 0; k < HALF; k++) begin
      if (splits[k].ok && (!lo_next.ok || splits[k].sum > lo_next.sum)) begin
        lo_next = splits[k];
      end
    end
    hi_next = '0;
    for (int k = HALF; k < NSPLIT; k++) begin
      if (splits[k].ok && (!hi_next.ok || splits[k].sum > hi_next.sum)) begin
        hi_next = splits[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= in_valid;
    end
    if (en) begin
      ctl3 <= ctl;
      lo3 <= lo_next;
      hi3 <= hi_next;
    end
  end

  assign best = (hi3.ok && (!lo3.ok || hi3.sum > lo3.sum)) ? hi3 : lo3;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
    if (en) begin
      if (ctl3.skip) begin
        char_count <= 2'd0;
        first_char <= '0;
        second_char <= '0;
      end else if (ctl3.exact) begin
        char_count <= 2'd1;
        first_char <= ctl3.exact_ch;
        second_char <= '0;
      end else if (best.ok && ctl3.room2) begin
        char_count <= 2'd2;
        first_char <= best.lch;
        second_char <= best.rch;
      end else begin
        char_count <= 2'd1;
        first_char <= mpd_pkg::UNKNOWN_CHAR;
        second_char <= '0;
      end
    end
  end

endmodule

// ----- rtl/morse_pattern_decoder_with_split.sv -----
// A beat accepted on s_axis passes the match input, split, pick select and output registers.
// One pattern per cycle unless stalled; a four-register pipeline with one shared enable.
// The pipeline halts as a whole while the output beat waits for m_tready.
// Reset clears only the stage valid bits; data registers are not reset.
module morse_pattern_decoder_with_split #(
  parameter int MAX_ELEMENTS = 15,
  parameter int TABLE_ENTRIES = 54
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // element_bits[14:0], element_count[18:15], room[20:19], zero fill above.
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // char_count[1:0], first_char[8:2], second_char[15:9].
  output logic [15:0] m_tdata
);

  logic                                   en;
  logic                                   v2;
  mpd_pkg::ctl_t                          ctl2;
  mpd_pkg::split_t [MAX_ELEMENTS-2:0]     splits2;
  logic [1:0]                             char_count;
  logic [mpd_pkg::CHAR_W-1:0]             first_char;
  logic [mpd_pkg::CHAR_W-1:0]             second_char;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  mpd_match #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_match (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (s_tvalid),
    .element_bits (s_tdata[14:0]),
    .element_count(s_tdata[18:15]),
    .room         (s_tdata[20:19]),
    .out_valid    (v2),
    .ctl          (ctl2),
    .splits       (splits2)
  );

  mpd_pick #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_pick (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (v2),
    .ctl        (ctl2),
    .splits     (splits2),
    .out_valid  (m_tvalid),
    .char_count (char_count),
    .first_char (first_char),
    .second_char(second_char)
  );

  assign m_tdata = {second_char, first_char, char_count};

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> char_count != 2'd3)
    else $error("char_count out of range");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && char_count == 2'd0) |-> (first_char == '0 && second_char == '0))
    else $error("empty result carries characters");

  a_single_no_second: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && char_count == 2'd1) |-> second_char == '0)
    else $error("single result carries a second character");

  a_pair_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && char_count == 2'd2) |-> (first_char != '0 && second_char != '0))
    else $error("pair result with an empty character");

endmodule
